FILE: src/rmv_pkg.sv
// Package for the running mean / variance block.
// Field widths, serial-unit sizes, iteration counts and the control structs
// shared by the shift-add multiplier, the restoring divider and the top level.
package rmv_pkg;

  // Default count width (samples per set up to 2^COUNT_BITS - 1)
  localparam int COUNT_BITS_DEF = 16;

  // Interface field widths
  localparam int SAMPLE_W = 32;
  localparam int MEAN_W   = 32;
  localparam int VAR_W    = 48;
  localparam int SCOUNT_W = 16;

  // Internal datapath widths
  localparam int ACC_W  = 48;  // mean accumulator, signed Q16.32
  localparam int SUM_W  = 64;  // sum of squared deviations, Q48.16
  localparam int MAG_W  = 49;  // |sample - mean| in Q.32
  localparam int FRAC_W = 16;  // bits dropped between Q.32 and Q.16
  localparam int RQ_W   = MAG_W - FRAC_W;  // quotient or magnitude in Q.16

  // Serial divider: 64-bit dividend shift register
  localparam int DVD_W      = 64;
  localparam int DIV_ITER_W = 7;
  localparam logic [DIV_ITER_W-1:0] DIV1_ITERS = DIV_ITER_W'(MAG_W);
  localparam logic [DIV_ITER_W-1:0] VAR_ITERS  = DIV_ITER_W'(DVD_W);

  // Serial multiplier: product kept modulo 2^64
  localparam int PROD_W     = 64;
  localparam int MPLR_W     = RQ_W;
  localparam int MUL_ITER_W = 6;
  localparam logic [MUL_ITER_W-1:0] MUL2_ITERS = MUL_ITER_W'(RQ_W);

  // Start request to the divider
  typedef struct packed {
    logic                  start;
    logic [DIV_ITER_W-1:0] iters;
  } div_ctl_t;

  // Start request to the multiplier
  typedef struct packed {
    logic                  start;
    logic [MUL_ITER_W-1:0] iters;
  } mul_ctl_t;

endpackage

FILE: src/rmv_if.sv
// Valid/ready channel interfaces for the running mean / variance block.
// Depends on rmv_pkg for the field widths.
interface rmv_in_if;
  import rmv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface rmv_out_if;
  import rmv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean;
  logic [VAR_W-1:0]         variance;
  logic                     variance_valid;
  logic [SCOUNT_W-1:0]      sample_count;
  logic                     saturated;

  modport source (output valid, mean, variance, variance_valid, sample_count, saturated,
                  input ready);
  modport sink   (input valid, mean, variance, variance_valid, sample_count, saturated,
                  output ready);
endinterface

FILE: src/rmv_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Depends on rmv_pkg; quotient bits shift into the dividend register.
module rmv_div #(
  parameter int DSR_W = rmv_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rmv_pkg::div_ctl_t         ctl,
  input  logic [rmv_pkg::DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0]          divisor,
  output logic [rmv_pkg::DVD_W-1:0] quotient,
  output logic                      done
);
  import rmv_pkg::*;

  logic                  busy;
  logic [DIV_ITER_W-1:0] cnt;
  logic [DVD_W-1:0]      dvd;
  logic [DSR_W-1:0]      dsr;
  logic [DSR_W-1:0]      rem;

  logic [DSR_W:0]   trial;
  logic             qbit;
  logic [DSR_W-1:0] rem_next;

  // One trial subtraction per cycle
  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
  end

  // Control: iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient = dvd;

endmodule

FILE: src/rmv_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on rmv_pkg; the product wraps modulo 2^PROD_W.
module rmv_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  rmv_pkg::mul_ctl_t          ctl,
  input  logic [rmv_pkg::PROD_W-1:0] multiplicand,
  input  logic [rmv_pkg::MPLR_W-1:0] multiplier,
  output logic [rmv_pkg::PROD_W-1:0] product,
  output logic                       done
);
  import rmv_pkg::*;

  logic                  busy;
  logic [MUL_ITER_W-1:0] cnt;
  logic [PROD_W-1:0]     acc;
  logic [PROD_W-1:0]     mcand;
  logic [MPLR_W-1:0]     mplr;

  // Control: iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MUL_ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: conditional add, shift multiplicand up and multiplier down
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc   <= '0;
      mcand <= multiplicand;
      mplr  <= multiplier;
    end else if (busy) begin
      if (mplr[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[PROD_W-2:0], 1'b0};
      mplr  <= {1'b0, mplr[MPLR_W-1:1]};
    end
  end

  assign product = acc;

endmodule

FILE: src/running_mean_variance_top.sv
// Running mean / unbiased variance of a Q16.16 sample stream (Welford update).
// Depends on rmv_pkg, rmv_if, rmv_div and rmv_mul.
//
// Usage:
//   samples (sink): one request carries a signed Q16.16 sample and a restart
//     flag; restart clears the set before the sample is taken.
//   stats (source): one request per sample with the truncated mean, the
//     unbiased variance (Q32.16, saturating), a valid flag for two or more
//     samples, the sample count and a flag for a sample dropped at the limit.
//   Each sample runs through one serial divider for sample-minus-mean over n
//   (49 steps), the shift-add multiplier twice (COUNT_BITS and 33 steps) and
//   the divider again for the variance (64 steps), one bit per cycle.
//   A sample dropped at the limit skips the first three passes; a count below
//   two skips the last pass. The result sits in an output register;
//   samples.ready rises again as soon as the result is stored, so the next
//   sample is taken while the result waits. A stalled stats channel holds
//   the next result until the pending one is taken.
//   Reset clears mean, sum and count and drops any pending result.
module running_mean_variance_top #(
  parameter int COUNT_BITS = rmv_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  rmv_in_if.sink    samples,
  rmv_out_if.source stats
);
  import rmv_pkg::*;

  localparam int T_W = RQ_W + COUNT_BITS;  // (|r| >> 16) * (n - 1)
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_DIV1W = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL1W = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_MUL2W = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_VAR   = 4'd9;
  localparam logic [3:0] S_VARW  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;

  // Running state
  logic [ACC_W-1:0]      mean_acc;
  logic [SUM_W-1:0]      dss;
  logic [COUNT_BITS-1:0] count;

  // Per-sample working registers
  logic [SAMPLE_W-1:0] sample_r;
  logic                sat_r;
  logic                d_neg;
  logic [MAG_W-1:0]    dmag;
  logic [RQ_W-1:0]     rq;
  logic [T_W-1:0]      t_r;
  logic [VAR_W-1:0]    incr_r;
  logic [VAR_W-1:0]    var_r;

  // Output register
  logic                     out_valid;
  logic signed [MEAN_W-1:0] o_mean;
  logic [VAR_W-1:0]         o_var;
  logic                     o_vvalid;
  logic [SCOUNT_W-1:0]      o_count;
  logic                     o_sat;

  // Serial units
  div_ctl_t              div_ctl;
  logic [DVD_W-1:0]      div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic [DVD_W-1:0]      div_q;
  logic                  div_done;
  mul_ctl_t              mul_ctl;
  logic [PROD_W-1:0]     mul_a;
  logic [MPLR_W-1:0]     mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic                  mul_done;

  // Datapath helpers
  logic              in_acc;
  logic              out_free;
  logic              two_plus;
  logic [MAG_W-1:0]  x49;
  logic [MAG_W-1:0]  m49;
  logic [MAG_W-1:0]  d_pos;
  logic [MAG_W-1:0]  d_inv;
  logic [MAG_W-1:0]  rmag;
  logic [SUM_W:0]    sum_ext;

  assign in_acc   = samples.valid && samples.ready;
  assign out_free = !out_valid || stats.ready;
  assign two_plus = (count > COUNT_BITS'(1));

  // Difference sample - mean in Q.32, both signs formed side by side
  always_comb begin
    x49   = {sample_r[SAMPLE_W-1], sample_r, {FRAC_W{1'b0}}};
    m49   = {mean_acc[ACC_W-1], mean_acc};
    d_pos = x49 - m49;
    d_inv = m49 - x49;
  end

  assign rmag    = div_q[MAG_W-1:0];
  assign sum_ext = {1'b0, dss} + {{(SUM_W - VAR_W + 1){1'b0}}, incr_r};

  // Unit requests and operand selection
  always_comb begin
    div_ctl.start = (state == S_DIV1) || (state == S_VAR && two_plus);
    div_ctl.iters = (state == S_DIV1) ? DIV1_ITERS : VAR_ITERS;
    if (state == S_DIV1) begin
      div_dividend = {dmag, {(DVD_W - MAG_W){1'b0}}};
      div_divisor  = count + 1'b1;
    end else begin
      div_dividend = dss;
      div_divisor  = count - 1'b1;
    end

    mul_ctl.start = (state == S_MUL1) || (state == S_MUL2);
    if (state == S_MUL1) begin
      mul_ctl.iters = MUL_ITER_W'(COUNT_BITS);
      mul_a         = PROD_W'(rq);
      mul_b         = MPLR_W'(count);
    end else begin
      mul_ctl.iters = MUL2_ITERS;
      mul_a         = PROD_W'(t_r);
      mul_b         = dmag[MAG_W-1:FRAC_W];
    end
  end

  rmv_div #(
    .DSR_W(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  rmv_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mul_ctl),
    .multiplicand (mul_a),
    .multiplier   (mul_b),
    .product      (mul_p),
    .done         (mul_done)
  );

  // Sequencer and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mean_acc  <= '0;
      dss       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output register: loaded from S_OUT, emptied when taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (stats.valid && stats.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (samples.restart) begin
              mean_acc <= '0;
              dss      <= '0;
              count    <= '0;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= sat_r ? S_VAR : S_DIV1;
        end
        S_DIV1: begin
          state <= S_DIV1W;
        end
        S_DIV1W: begin
          if (div_done) begin
            // mean += r, with r = +/- |d| / n taken modulo 2^48
            mean_acc <= mean_acc + (rmag[ACC_W-1:0] ^ {ACC_W{d_neg}})
                        + ACC_W'(d_neg);
            state    <= S_MUL1;
          end
        end
        S_MUL1: begin
          state <= S_MUL1W;
        end
        S_MUL1W: begin
          if (mul_done) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          state <= S_MUL2W;
        end
        S_MUL2W: begin
          if (mul_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          // saturating accumulate, then n becomes the count
          dss   <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
          count <= count + 1'b1;
          state <= S_VAR;
        end
        S_VAR: begin
          state <= two_plus ? S_VARW : S_OUT;
        end
        S_VARW: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      sample_r <= samples.sample;
      sat_r    <= !samples.restart && (count == COUNT_LIMIT);
    end
    if (state == S_PREP) begin
      d_neg <= d_pos[MAG_W-1];
      dmag  <= d_pos[MAG_W-1] ? d_inv : d_pos;
    end
    if (state == S_DIV1W && div_done) begin
      rq <= rmag[MAG_W-1:FRAC_W];
    end
    if (state == S_MUL1W && mul_done) begin
      t_r <= mul_p[T_W-1:0];
    end
    if (state == S_MUL2W && mul_done) begin
      incr_r <= mul_p[PROD_W-1:FRAC_W];
    end
    if (state == S_VAR && !two_plus) begin
      var_r <= '0;
    end
    if (state == S_VARW && div_done) begin
      var_r <= (|div_q[DVD_W-1:VAR_W]) ? {VAR_W{1'b1}} : div_q[VAR_W-1:0];
    end
    if (state == S_OUT && out_free) begin
      o_mean   <= mean_acc[ACC_W-1:FRAC_W];
      o_var    <= var_r;
      o_vvalid <= two_plus;
      o_count  <= SCOUNT_W'(count);
      o_sat    <= sat_r;
    end
  end

  // Channel drive
  assign samples.ready        = (state == S_IDLE);
  assign stats.valid          = out_valid;
  assign stats.mean           = o_mean;
  assign stats.variance       = o_var;
  assign stats.variance_valid = o_vvalid;
  assign stats.sample_count   = o_count;
  assign stats.saturated      = o_sat;

endmodule

FILE: src/rmv_checker.sv
// Port-level checks for the running mean / variance block, bound to the top.
// Depends on rmv_pkg for field widths.
module rmv_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rmv_pkg::MEAN_W-1:0] mean,
  input logic [rmv_pkg::VAR_W-1:0]  variance,
  input logic                       variance_valid,
  input logic                       saturated
);
  import rmv_pkg::*;

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result still offered after reset");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean) && $stable(variance))
    else $error("stalled result changed");

  // One sample at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while a sample is in work");

  // Variance reads zero until two samples are in the set
  a_var_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !variance_valid |-> variance == '0)
    else $error("variance nonzero below two samples");

  // A dropped sample only happens at a full set, so it comes with a valid variance
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> variance_valid)
    else $error("saturation reported below two samples");

endmodule

bind running_mean_variance_top rmv_checker u_rmv_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .out_valid      (stats.valid),
  .out_ready      (stats.ready),
  .mean           (stats.mean),
  .variance       (stats.variance),
  .variance_valid (stats.variance_valid),
  .saturated      (stats.saturated)
);
